// ===== rtl/triangle_unit_normal_macros.svh =====
// assertion helpers for the triangle normal pipeline
`ifndef TRIANGLE_UNIT_NORMAL_MACROS_SVH
`define TRIANGLE_UNIT_NORMAL_MACROS_SVH

// same-cycle implication
`define TUN_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TUN_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/tun_pkg.sv =====
package tun_pkg;
   localparam int CoordW     = 16;
   localparam int EdgeW      = 17;
   localparam int ProdW      = 34;
   localparam int CrossW     = 35;
   localparam int MagW       = 34;
   localparam int LenW       = 6;
   localparam int UnitW      = 30;
   localparam int SqW        = 60;
   localparam int SumW       = 62;
   localparam int RootW      = 31;
   localparam int RemW       = 34;
   localparam int FracW      = 14;
   localparam int DivW       = 45;
   localparam int QuotW      = 15;
   localparam int OutW       = 16;
   localparam int TargetBits = 30;
   localparam int SqrtSteps  = 31;
   localparam int DivSteps   = 15;
   localparam int Lat        = 57;

   localparam logic [QuotW-1:0] NormOne = 15'd16384;

   typedef struct packed {
      logic [2:0] neg;
      logic       deg;
   } tag_type;
endpackage

// ===== rtl/triangle_unit_normal.sv =====
// triangle_unit_normal
// Unit face normal of a triangle. Each req beat carries three vertices A, B, C
// as nine signed Q7.8 coordinates; each rsp beat carries the normal of
// (B - A) x (C - A) scaled to unit length as three signed Q1.14 components,
// with rsp_tuser high for a degenerate (zero-area) triangle, whose normal is
// then zero. Exactly one rsp beat follows every req beat, in order.
// The pipeline has 57 register stages and takes one triangle per cycle
// while rsp_tready does not hold it: edges, cross product, magnitude and
// leading-one search take nine stages, the square root resolves one root
// bit per stage (31 stages), one stage forms the rounded dividends, the
// three divisions resolve one quotient bit per stage (15 stages) in
// parallel lanes, plus one output register.
// Reset clears all valid bits; payload registers are not reset.
// When rsp_tready is low while a result waits, the whole pipeline holds and
// req_tready drops in the same cycle; nothing is lost or repeated.
`include "triangle_unit_normal_macros.svh"

module triangle_unit_normal
   import tun_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
   input  logic [143:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // norm_x, norm_y, norm_z
   output logic [47:0]  rsp_tdata,
   // degenerate
   output logic         rsp_tuser
);

   logic [Lat-1:0] vld_ff;
   logic           en;

   logic signed [CoordW-1:0] crd [9];
   logic signed [EdgeW-1:0]  e1_ff [3];
   logic signed [EdgeW-1:0]  e2_ff [3];
   logic signed [ProdW-1:0]  prod_ff [6];
   logic signed [CrossW-1:0] crs_ff [3];
   logic [MagW-1:0]          mag4_ff [3];
   logic [MagW-1:0]          mag5_ff [3];
   logic [MagW-1:0]          mag6_ff [3];
   logic [2:0]               neg4_ff, neg5_ff, neg6_ff;
   logic [MagW-1:0]          max5_ff;
   logic [LenW-1:0]          len6_ff;
   logic [LenW-1:0]          len_in;
   logic [UnitW-1:0]         u7_ff [3];
   logic [UnitW-1:0]         u8_ff [3];
   logic [UnitW-1:0]         u9_ff [3];
   tag_type                  tag7_ff, tag8_ff, tag9_ff;
   logic [SqW-1:0]           sq8_ff [3];
   logic [SumW-1:0]          sum9_ff;

   logic [RemW-1:0]  sq_rem_ff  [SqrtSteps];
   logic [RemW-1:0]  sq_rem_in  [SqrtSteps];
   logic [RootW-1:0] root_ff    [SqrtSteps];
   logic [RootW-1:0] root_in    [SqrtSteps];
   logic [SumW-1:0]  rad_ff     [SqrtSteps];
   logic [SumW-1:0]  rad_in     [SqrtSteps];
   logic [UnitW-1:0] sq_u_ff    [SqrtSteps][3];
   tag_type          sq_tag_ff  [SqrtSteps];

   logic [DivW-1:0]  dp_rem_ff [3];
   logic [RootW-1:0] dp_dsr_ff;
   tag_type          dp_tag_ff;

   logic [DivW-1:0]  dv_rem_ff [DivSteps][3];
   logic [DivW-1:0]  dv_rem_in [DivSteps][3];
   logic [QuotW-1:0] dv_q_ff   [DivSteps][3];
   logic [QuotW-1:0] dv_q_in   [DivSteps][3];
   logic [RootW-1:0] dv_dsr_ff [DivSteps];
   tag_type          dv_tag_ff [DivSteps];

   logic [47:0] out_ff;
   logic        outdeg_ff;
   logic [47:0] out_in;

   assign en         = !vld_ff[Lat-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[Lat-1];
   assign rsp_tdata  = out_ff;
   assign rsp_tuser  = outdeg_ff;

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         crd[i] = req_tdata[i*CoordW +: CoordW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[Lat-2:0], req_tvalid};
      end
   end

   // bit length (leading-one position plus one) of the largest magnitude
   always_comb begin
      len_in = '0;
      for (int b = 0; b < MagW; b++) begin
         if (max5_ff[b]) begin
            len_in = LenW'(b + 1);
         end
      end
   end

   // front: edges, products, cross, magnitude, max, length, scale, squares, sum
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[i] <= EdgeW'(crd[3+i]) - EdgeW'(crd[i]);
            e2_ff[i] <= EdgeW'(crd[6+i]) - EdgeW'(crd[i]);
         end
         prod_ff[0] <= ProdW'(e1_ff[1]) * ProdW'(e2_ff[2]);
         prod_ff[1] <= ProdW'(e1_ff[2]) * ProdW'(e2_ff[1]);
         prod_ff[2] <= ProdW'(e1_ff[2]) * ProdW'(e2_ff[0]);
         prod_ff[3] <= ProdW'(e1_ff[0]) * ProdW'(e2_ff[2]);
         prod_ff[4] <= ProdW'(e1_ff[0]) * ProdW'(e2_ff[1]);
         prod_ff[5] <= ProdW'(e1_ff[1]) * ProdW'(e2_ff[0]);
         for (int i = 0; i < 3; i++) begin
            crs_ff[i]  <= CrossW'(prod_ff[2*i]) - CrossW'(prod_ff[2*i+1]);
            mag4_ff[i] <= crs_ff[i][CrossW-1] ? MagW'(-crs_ff[i]) : MagW'(crs_ff[i]);
         end
         neg4_ff <= {crs_ff[2][CrossW-1], crs_ff[1][CrossW-1], crs_ff[0][CrossW-1]};
         mag5_ff <= mag4_ff;
         neg5_ff <= neg4_ff;
         if (mag4_ff[0] >= mag4_ff[1] && mag4_ff[0] >= mag4_ff[2]) begin
            max5_ff <= mag4_ff[0];
         end else if (mag4_ff[1] >= mag4_ff[2]) begin
            max5_ff <= mag4_ff[1];
         end else begin
            max5_ff <= mag4_ff[2];
         end
         mag6_ff <= mag5_ff;
         neg6_ff <= neg5_ff;
         len6_ff <= len_in;
         for (int i = 0; i < 3; i++) begin
            if (len6_ff > LenW'(TargetBits)) begin
               u7_ff[i] <= UnitW'(mag6_ff[i] >> (len6_ff - LenW'(TargetBits)));
            end else begin
               u7_ff[i] <= UnitW'(mag6_ff[i] << (LenW'(TargetBits) - len6_ff));
            end
         end
         tag7_ff <= '{neg: neg6_ff, deg: (len6_ff == '0)};
         for (int i = 0; i < 3; i++) begin
            sq8_ff[i] <= SqW'(u7_ff[i]) * SqW'(u7_ff[i]);
         end
         u8_ff   <= u7_ff;
         tag8_ff <= tag7_ff;
         sum9_ff <= SumW'(sq8_ff[0]) + SumW'(sq8_ff[1]) + SumW'(sq8_ff[2]);
         u9_ff   <= u8_ff;
         tag9_ff <= tag8_ff;
      end
   end

   // square root, one root bit per stage
   always_comb begin
      logic [SumW-1:0]  t_rad;
      logic [RemW-1:0]  t_rem;
      logic [RootW-1:0] t_root;
      logic [RemW-1:0]  t_shift;
      logic [RemW-1:0]  t_trial;
      for (int k = 0; k < SqrtSteps; k++) begin
         if (k == 0) begin
            t_rad  = sum9_ff;
            t_rem  = '0;
            t_root = '0;
         end else begin
            t_rad  = rad_ff[k-1];
            t_rem  = sq_rem_ff[k-1];
            t_root = root_ff[k-1];
         end
         t_shift = {t_rem[RemW-3:0], t_rad[SumW-1 -: 2]};
         t_trial = {1'b0, t_root, 2'b01};
         if (t_shift >= t_trial) begin
            sq_rem_in[k] = t_shift - t_trial;
            root_in[k]   = {t_root[RootW-2:0], 1'b1};
         end else begin
            sq_rem_in[k] = t_shift;
            root_in[k]   = {t_root[RootW-2:0], 1'b0};
         end
         rad_in[k] = {t_rad[SumW-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < SqrtSteps; k++) begin
            sq_rem_ff[k] <= sq_rem_in[k];
            root_ff[k]   <= root_in[k];
            rad_ff[k]    <= rad_in[k];
            if (k == 0) begin
               sq_u_ff[k]   <= u9_ff;
               sq_tag_ff[k] <= tag9_ff;
            end else begin
               sq_u_ff[k]   <= sq_u_ff[k-1];
               sq_tag_ff[k] <= sq_tag_ff[k-1];
            end
         end
         for (int i = 0; i < 3; i++) begin
            dp_rem_ff[i] <= {sq_u_ff[SqrtSteps-1][i], FracW'(0)}
                            + DivW'(root_ff[SqrtSteps-1] >> 1);
         end
         dp_dsr_ff <= root_ff[SqrtSteps-1];
         dp_tag_ff <= sq_tag_ff[SqrtSteps-1];
      end
   end

   // restoring division, one quotient bit per stage, three lanes
   always_comb begin
      logic [DivW-1:0]  t_rem;
      logic [QuotW-1:0] t_q;
      logic [RootW-1:0] t_dsr;
      logic [DivW-1:0]  t_cmp;
      for (int k = 0; k < DivSteps; k++) begin
         for (int i = 0; i < 3; i++) begin
            if (k == 0) begin
               t_rem = dp_rem_ff[i];
               t_q   = '0;
               t_dsr = dp_dsr_ff;
            end else begin
               t_rem = dv_rem_ff[k-1][i];
               t_q   = dv_q_ff[k-1][i];
               t_dsr = dv_dsr_ff[k-1];
            end
            t_cmp = DivW'(t_dsr) << (DivSteps - 1 - k);
            if (t_rem >= t_cmp) begin
               dv_rem_in[k][i] = t_rem - t_cmp;
               dv_q_in[k][i]   = {t_q[QuotW-2:0], 1'b1};
            end else begin
               dv_rem_in[k][i] = t_rem;
               dv_q_in[k][i]   = {t_q[QuotW-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DivSteps; k++) begin
            dv_rem_ff[k] <= dv_rem_in[k];
            dv_q_ff[k]   <= dv_q_in[k];
            if (k == 0) begin
               dv_dsr_ff[k] <= dp_dsr_ff;
               dv_tag_ff[k] <= dp_tag_ff;
            end else begin
               dv_dsr_ff[k] <= dv_dsr_ff[k-1];
               dv_tag_ff[k] <= dv_tag_ff[k-1];
            end
         end
      end
   end

   // clamp, sign, degenerate override
   always_comb begin
      logic [QuotW-1:0] t_mag;
      for (int i = 0; i < 3; i++) begin
         t_mag = dv_q_ff[DivSteps-1][i];
         if (t_mag > NormOne) begin
            t_mag = NormOne;
         end
         if (dv_tag_ff[DivSteps-1].deg) begin
            out_in[i*OutW +: OutW] = '0;
         end else if (dv_tag_ff[DivSteps-1].neg[i]) begin
            out_in[i*OutW +: OutW] = -OutW'(t_mag);
         end else begin
            out_in[i*OutW +: OutW] = OutW'(t_mag);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff    <= out_in;
         outdeg_ff <= dv_tag_ff[DivSteps-1].deg;
      end
   end

   `TUN_ASSERT_IMP(a_deg_zero, rsp_tvalid && rsp_tuser, rsp_tdata == '0,
                   "degenerate beat with nonzero normal")
   `TUN_ASSERT_IMP(a_root_range,
                   vld_ff[9+SqrtSteps-1] && !sq_tag_ff[SqrtSteps-1].deg,
                   root_ff[SqrtSteps-1][RootW-1] || root_ff[SqrtSteps-1][RootW-2],
                   "square root below normalized range")
   `TUN_ASSERT_NXT(a_stall_hold, !en, $stable(vld_ff) && $stable(out_ff),
                   "pipeline moved while stalled")

endmodule
